// ----- hw/rtl/tbo_pkg.sv -----
// Shared widths for the triangle / box overlap pipeline.
package tbo_pkg;
    localparam int CW  = 24;          // coordinate width
    localparam int XW  = CW + 1;      // center, extent and edge width
    localparam int VW  = CW + 3;      // vertex relative to double-scale center
    localparam int FW  = XW + 1;      // negated or absolute edge component
    localparam int MW  = VW + FW;     // projection partial product
    localparam int PW  = MW + 1;      // projection
    localparam int QW  = XW + FW;     // radius partial product
    localparam int RW  = QW + 1;      // radius
    localparam int IXW = 3;           // configuration index width

    typedef enum logic [IXW-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;
endpackage

// ----- hw/rtl/triangle_box_overlap_test_core.sv -----
// Triangle versus axis-aligned box overlap test, four stage pipeline.
// Stages: four register stages, r1 to r4, lie between the clock edge that
// accepts the input word and the output word.
// Throughput: one word per cycle; the four stage registers stall together
// when the output word is not taken.
// Reset: synchronous active low; clears stage valid bits and box registers.
module triangle_box_overlap_test_core
    import tbo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IXW-1:0]       i_cfg_idx,
    input  logic [CW-1:0]        i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [CW-1:0] i_a_x,
    input  logic signed [CW-1:0] i_a_y,
    input  logic signed [CW-1:0] i_a_z,
    input  logic signed [CW-1:0] i_b_x,
    input  logic signed [CW-1:0] i_b_y,
    input  logic signed [CW-1:0] i_b_z,
    input  logic signed [CW-1:0] i_c_x,
    input  logic signed [CW-1:0] i_c_y,
    input  logic signed [CW-1:0] i_c_z,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_overlaps
);
    logic signed [CW-1:0] r_bmin [3];
    logic signed [CW-1:0] r_bmax [3];
    logic [3:0]           r_v;
    logic                 w_en;

    logic signed [CW-1:0] w_pt   [3][3];
    logic signed [XW-1:0] w_ctr  [3];
    logic signed [XW-1:0] n_ext  [3];
    logic signed [VW-1:0] n_vtx  [3][3];
    logic signed [XW-1:0] n_edge [3][3];
    logic signed [FW-1:0] n_nf   [3][3];
    logic signed [FW-1:0] n_af   [3][3];

    logic signed [XW-1:0] r1_ext  [3];
    logic signed [VW-1:0] r1_vtx  [3][3];
    logic signed [XW-1:0] r1_edge [3][3];
    logic signed [FW-1:0] r1_nf   [3][3];
    logic signed [FW-1:0] r1_af   [3][3];

    logic signed [MW-1:0] n_pa [3][3][3];
    logic signed [MW-1:0] n_pb [3][3][3];
    logic signed [QW-1:0] n_ra [3][3];
    logic signed [QW-1:0] n_rb [3][3];
    logic                 n_boxsep;
    logic signed [MW-1:0] r2_pa [3][3][3];
    logic signed [MW-1:0] r2_pb [3][3][3];
    logic signed [QW-1:0] r2_ra [3][3];
    logic signed [QW-1:0] r2_rb [3][3];
    logic                 r2_boxsep;

    logic signed [PW-1:0] n_p [3][3][3];
    logic signed [RW-1:0] n_r [3][3];
    logic signed [PW-1:0] r3_p [3][3][3];
    logic signed [RW-1:0] r3_r [3][3];
    logic                 r3_boxsep;

    logic                 n_hit;
    logic                 r4_hit;

    assign w_en        = !r_v[3] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_v[3];
    assign o_overlaps  = r4_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_bmin[a] <= '0;
                r_bmax[a] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_X: r_bmin[0] <= i_cfg_data;
                REG_MIN_Y: r_bmin[1] <= i_cfg_data;
                REG_MIN_Z: r_bmin[2] <= i_cfg_data;
                REG_MAX_X: r_bmax[0] <= i_cfg_data;
                REG_MAX_Y: r_bmax[1] <= i_cfg_data;
                REG_MAX_Z: r_bmax[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: recenter at double scale, edges
    always_comb begin
        w_pt[0][0] = i_a_x; w_pt[0][1] = i_a_y; w_pt[0][2] = i_a_z;
        w_pt[1][0] = i_b_x; w_pt[1][1] = i_b_y; w_pt[1][2] = i_b_z;
        w_pt[2][0] = i_c_x; w_pt[2][1] = i_c_y; w_pt[2][2] = i_c_z;
        for (int a = 0; a < 3; a++) begin
            w_ctr[a] = XW'(r_bmin[a]) + XW'(r_bmax[a]);
            n_ext[a] = XW'(r_bmax[a]) - XW'(r_bmin[a]);
            for (int n = 0; n < 3; n++) begin
                n_vtx[n][a]  = (VW'(w_pt[n][a]) <<< 1) - VW'(w_ctr[a]);
                n_edge[n][a] = XW'(w_pt[(n + 1) % 3][a]) - XW'(w_pt[n][a]);
                n_nf[n][a]   = -FW'(n_edge[n][a]);
                n_af[n][a]   = n_edge[n][a][XW-1] ? n_nf[n][a] : FW'(n_edge[n][a]);
            end
        end
    end

    // stage 2: products, box-axis test
    always_comb begin
        logic signed [VW-1:0] lo, hi;
        logic signed [FW-1:0] ne;
        n_boxsep = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int f = 0; f < 3; f++) begin
                n_ra[i][f] = QW'(r1_ext[(i + 1) % 3]) * QW'(r1_af[f][(i + 2) % 3]);
                n_rb[i][f] = QW'(r1_ext[(i + 2) % 3]) * QW'(r1_af[f][(i + 1) % 3]);
                for (int n = 0; n < 3; n++) begin
                    n_pa[i][f][n] = MW'(r1_vtx[n][(i + 1) % 3]) *
                                    MW'(r1_nf[f][(i + 2) % 3]);
                    n_pb[i][f][n] = MW'(r1_vtx[n][(i + 2) % 3]) *
                                    MW'(r1_edge[f][(i + 1) % 3]);
                end
            end
            lo = r1_vtx[0][i];
            hi = r1_vtx[0][i];
            for (int n = 1; n < 3; n++) begin
                if (r1_vtx[n][i] < lo) lo = r1_vtx[n][i];
                if (r1_vtx[n][i] > hi) hi = r1_vtx[n][i];
            end
            ne = -FW'(r1_ext[i]);
            if (hi < VW'(ne) || lo > VW'(r1_ext[i]))
                n_boxsep = 1'b1;
        end
    end

    // stage 3: projections and radii
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int f = 0; f < 3; f++) begin
                n_r[i][f] = RW'(r2_ra[i][f]) + RW'(r2_rb[i][f]);
                for (int n = 0; n < 3; n++)
                    n_p[i][f][n] = PW'(r2_pa[i][f][n]) + PW'(r2_pb[i][f][n]);
            end
        end
    end

    // stage 4: interval versus radius
    always_comb begin
        logic signed [PW-1:0] lo, hi;
        logic signed [PW:0]   nhi;
        n_hit = !r3_boxsep;
        for (int i = 0; i < 3; i++) begin
            for (int f = 0; f < 3; f++) begin
                lo = r3_p[i][f][0];
                hi = r3_p[i][f][0];
                for (int n = 1; n < 3; n++) begin
                    if (r3_p[i][f][n] < lo) lo = r3_p[i][f][n];
                    if (r3_p[i][f][n] > hi) hi = r3_p[i][f][n];
                end
                nhi = -(PW + 1)'(hi);
                if ((PW + 1)'(lo) > (PW + 1)'(r3_r[i][f]) ||
                    nhi > (PW + 1)'(r3_r[i][f]))
                    n_hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ext    <= n_ext;
            r1_vtx    <= n_vtx;
            r1_edge   <= n_edge;
            r1_nf     <= n_nf;
            r1_af     <= n_af;
            r2_pa     <= n_pa;
            r2_pb     <= n_pb;
            r2_ra     <= n_ra;
            r2_rb     <= n_rb;
            r2_boxsep <= n_boxsep;
            r3_p      <= n_p;
            r3_r      <= n_r;
            r3_boxsep <= r2_boxsep;
            r4_hit    <= n_hit;
        end
    end
endmodule

// ----- tb/sv/triangle_box_overlap_test_core_tb.sv -----
// Testbench for the triangle / box overlap core: directed and random triangles.
`timescale 1ns / 1ps
module triangle_box_overlap_test_core_tb;
    import tbo_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IXW-1:0]       i_cfg_idx;
    logic [CW-1:0]        i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_overlaps;

    triangle_box_overlap_test_core uut (.*);

    logic signed [CW-1:0] box_lo [3];
    logic signed [CW-1:0] box_hi [3];
    bit                   overlap_q [$];
    int                   err_cnt;
    bit                   stall_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("triangle_box_overlap_test_core_tb: done, errors");
        $finish;
    end

    function automatic bit predict_overlap(input logic signed [CW-1:0] p [9]);
        longint ctr [3], ext [3], vtx [3][3], edg [3][3], f [3];
        logic signed [127:0] pr [3], lo, hi, rad;
        int j, k;
        bit hit;
        hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            ctr[a] = longint'(box_lo[a]) + longint'(box_hi[a]);
            ext[a] = longint'(box_hi[a]) - longint'(box_lo[a]);
        end
        for (int n = 0; n < 3; n++)
            for (int a = 0; a < 3; a++)
                vtx[n][a] = 2 * longint'(p[n*3+a]) - ctr[a];
        for (int a = 0; a < 3; a++) begin
            edg[0][a] = longint'(p[3+a]) - longint'(p[a]);
            edg[1][a] = longint'(p[6+a]) - longint'(p[3+a]);
            edg[2][a] = longint'(p[a]) - longint'(p[6+a]);
        end
        for (int i = 0; i < 3; i++)
            for (int e = 0; e < 3; e++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                f = edg[e];
                for (int n = 0; n < 3; n++)
                    pr[n] = 128'(vtx[n][j]) * 128'(-f[k]) + 128'(vtx[n][k]) * 128'(f[j]);
                lo = pr[0];
                hi = pr[0];
                for (int n = 1; n < 3; n++) begin
                    if (pr[n] < lo) lo = pr[n];
                    if (pr[n] > hi) hi = pr[n];
                end
                rad = 128'(ext[j]) * 128'(f[k] < 0 ? -f[k] : f[k])
                    + 128'(ext[k]) * 128'(f[j] < 0 ? -f[j] : f[j]);
                if (-hi > rad || lo > rad) hit = 1'b0;
            end
        for (int a = 0; a < 3; a++) begin
            longint l, h;
            l = vtx[0][a];
            h = vtx[0][a];
            for (int n = 1; n < 3; n++) begin
                if (vtx[n][a] < l) l = vtx[n][a];
                if (vtx[n][a] > h) h = vtx[n][a];
            end
            if (h < -ext[a] || l > ext[a]) hit = 1'b0;
        end
        return hit;
    endfunction

    // result checker with random stall on the output side
    initial begin
        int w;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = stall_on ? $urandom_range(0, 5) : 0;
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk iff o_out_valid);
            if (overlap_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual overlaps=%0b",
                         $time, o_overlaps);
                err_cnt++;
            end else begin
                bit x;
                x = overlap_q.pop_front();
                if (x !== o_overlaps) begin
                    $display("%0t: overlaps expected %0b actual %0b", $time, x, o_overlaps);
                    err_cnt++;
                end
            end
        end
    end

    task automatic send_triangle(input logic signed [CW-1:0] p [9]);
        int w;
        w = stall_on ? $urandom_range(0, 5) : 0;
        if (w > 0) begin
            i_in_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        {i_a_x, i_a_y, i_a_z} <= {p[0], p[1], p[2]};
        {i_b_x, i_b_y, i_b_z} <= {p[3], p[4], p[5]};
        {i_c_x, i_c_y, i_c_z} <= {p[6], p[7], p[8]};
        i_in_valid <= 1'b1;
        @(posedge i_clk iff o_in_ready);
        overlap_q = {overlap_q, predict_overlap(p)};
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (overlap_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_box(input logic signed [CW-1:0] lo [3], input logic signed [CW-1:0] hi [3]);
        t_reg_idx r;
        for (int a = 0; a < 6; a++) begin
            r = t_reg_idx'(a);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r;
            i_cfg_data <= (a < 3) ? lo[a] : hi[a-3];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        box_lo = lo;
        box_hi = hi;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(input int span);
        case ($urandom_range(0, 9))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return CW'($urandom);
            default: return CW'($urandom_range(0, 2 * span)) - CW'(span);
        endcase
    endfunction

    task automatic test_directed;
        logic signed [CW-1:0] p [9];
        logic signed [CW-1:0] mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        set_box('{-256, -256, -256}, '{256, 256, 256});
        p = '{0, 0, 0, 128, 0, 0, 0, 128, 0};          send_triangle(p);
        p = '{512, 512, 512, 768, 512, 512, 512, 768, 512}; send_triangle(p);
        p = '{256, 0, 0, 512, 0, 0, 512, 128, 0};      send_triangle(p);   // touching face
        p = '{100, 100, 100, 100, 100, 100, 100, 100, 100}; send_triangle(p); // point
        p = '{-300, 0, 0, 300, 0, 0, 300, 0, 0};       send_triangle(p);   // zero edge
        p = '{mx, mx, mx, mn, mn, mn, mx, mn, mx};     send_triangle(p);
        p = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};     send_triangle(p);
        p = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};     send_triangle(p);
        p = '{mn, mx, 0, mx, mn, 0, 0, 0, mx};         send_triangle(p);
        p = '{600, -10, 0, -10, 600, 0, 600, 600, 0};  send_triangle(p);  // edge-axis miss
        drain();
        set_box('{mn, mn, mn}, '{mx, mx, mx});
        p = '{mx, mx, mx, mn, mn, mn, 0, 0, 0};        send_triangle(p);
        p = '{mn, mx, mn, mx, mn, mx, mx, mx, mn};     send_triangle(p);
        drain();
        set_box('{256, 256, 256}, '{-256, -256, -256});  // inverted
        p = '{0, 0, 0, 128, 0, 0, 0, 128, 0};          send_triangle(p);
        p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};              send_triangle(p);
        drain();
        set_box('{0, 0, 0}, '{0, 0, 0});
        p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};              send_triangle(p);
        p = '{-5, 0, 0, 5, 0, 0, 0, 5, 0};             send_triangle(p);
        drain();
    endtask

    task automatic test_random(input int n_items, input int span);
        logic signed [CW-1:0] p [9];
        logic signed [CW-1:0] lo [3], hi [3], c, h;
        for (int a = 0; a < 3; a++) begin
            c = CW'($urandom_range(0, 2 * span)) - CW'(span);
            h = CW'($urandom_range(0, span));
            if ($urandom_range(0, 15) == 0) h = -h;
            lo[a] = c - h;
            hi[a] = c + h;
        end
        if ($urandom_range(0, 5) == 0) begin
            lo[0] = CW'($urandom);
            hi[1] = CW'($urandom);
        end
        set_box(lo, hi);
        for (int i = 0; i < n_items; i++) begin
            for (int k = 0; k < 9; k++) p[k] = rand_coord(span * 2);
            send_triangle(p);
        end
        drain();
    endtask

    initial begin
        err_cnt    = 0;
        stall_on   = 1'b1;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} = '0;
        box_lo = '{0, 0, 0};
        box_hi = '{0, 0, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        for (int r = 0; r < 30; r++) begin
            stall_on = (r % 4 != 3);
            test_random(50, (r % 3 == 0) ? 2000 : (r % 3 == 1) ? 60000 : 4000000);
        end
        if (err_cnt == 0)
            $display("triangle_box_overlap_test_core_tb: done, clean");
        else
            $display("triangle_box_overlap_test_core_tb: done, errors");
        $finish;
    end
endmodule
